// ===== rtl/core/ntpcal_pkg.sv =====
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared types, register indexes and constants for the NTP seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_MIN_VALID   = 8'd0;
  localparam logic [7:0] REG_ZONE_OFFSET = 8'd1;

  localparam logic [31:0] MIN_VALID_RESET   = 32'd3913056000;
  localparam logic [16:0] ZONE_OFFSET_RESET = 17'd25200;

  // NTP seconds at 2000-01-01 00:00:00 UTC
  localparam logic [33:0] NTP_AT_2000 = 34'd3155673600;

  // 86400 = 675 * 128
  localparam logic [9:0]  DAY_UNIT   = 10'd675;
  localparam logic [14:0] RECIP_675  = 15'((64'd1 << 24) / 64'd675);

  // days from 1996-03-01 to 2000-01-01; four-year cycles hold up to 2099
  localparam logic [15:0] SHIFT_1996  = 16'd1401;
  localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
  localparam logic [5:0]  RECIP_1461  = 6'((64'd1 << 16) / 64'd1461);

  // 2000-01-01 was a Saturday
  localparam logic [15:0] WEEK_SHIFT = 16'd6;
  localparam logic [13:0] RECIP_7    = 14'((64'd1 << 16) / 64'd7);

  // 3600 = 225 * 16, 60 = 15 * 4
  localparam logic [7:0] HOUR_UNIT  = 8'd225;
  localparam logic [5:0] RECIP_225  = 6'((64'd1 << 13) / 64'd225);
  localparam logic [3:0] MIN_UNIT   = 4'd15;
  localparam logic [6:0] RECIP_15   = 7'((64'd1 << 10) / 64'd15);

  typedef struct packed {
    logic [31:0] min_valid;
    logic [16:0] zone_offset;
  } cfg_t;

  // first day of each month of a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/ntpcal_conv.sv =====
// ----------------------------------------------------------------------------
// ntpcal_conv
// Seven-stage conversion pipeline: epoch shift, day split, four-year cycle,
// year of cycle, month and day, with time of day and weekday alongside.
// ----------------------------------------------------------------------------
module ntpcal_conv (
  input  logic                  clk,
  input  logic                  rst,
  input  ntpcal_pkg::cfg_t      cfg,
  input  logic                  ntp_valid,
  output logic                  ntp_stall,
  input  logic [31:0]           ntp_seconds,
  output logic                  cal_valid,
  input  logic                  cal_stall,
  output logic                  status,
  output logic [6:0]            year_in_century,
  output logic [3:0]            month,
  output logic [4:0]            day_of_month,
  output logic [2:0]            weekday,
  output logic [4:0]            hour,
  output logic [5:0]            minute,
  output logic [5:0]            second
);

  logic       adv;
  logic [6:0] vld;

  assign adv       = !(vld[6] && cal_stall);
  assign ntp_stall = !adv;
  assign cal_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[5:0], ntp_valid};
    end
  end

  // stage a: shift to seconds since 2000 in local time
  logic [33:0] a_sum;
  logic        a_inv;
  logic [30:0] a_secs;

  assign a_sum = {2'b00, ntp_seconds} + {{17{cfg.zone_offset[16]}}, cfg.zone_offset}
                 - ntpcal_pkg::NTP_AT_2000;

  // stage b: day estimate
  logic [38:0] b_prod;
  logic        b_inv;
  logic [14:0] b_q;
  logic [23:0] b_x;
  logic [6:0]  b_lo;

  assign b_prod = 39'(a_secs[30:7]) * 39'(ntpcal_pkg::RECIP_675);

  // stage c: day correction
  logic [24:0] c_prod;
  logic [24:0] c_diff;
  logic [10:0] c_r;
  logic        c_over;
  logic [10:0] c_rr;
  logic        c_inv;
  logic [14:0] c_days;
  logic [16:0] c_secs;

  assign c_prod = 25'(b_q) * 25'(ntpcal_pkg::DAY_UNIT);
  assign c_diff = {1'b0, b_x} - c_prod;
  assign c_r    = c_diff[10:0];
  assign c_over = c_r >= 11'(ntpcal_pkg::DAY_UNIT);
  assign c_rr   = c_over ? c_r - 11'(ntpcal_pkg::DAY_UNIT) : c_r;

  // stage d: cycle, hour and week estimates
  logic [15:0] d_d3_n;
  logic [15:0] d_w_n;
  logic [21:0] d_cprod;
  logic [18:0] d_hprod;
  logic [29:0] d_wprod;
  logic        d_inv;
  logic [15:0] d_d3;
  logic [15:0] d_w;
  logic [12:0] d_h;
  logic [3:0]  d_lo;
  logic [5:0]  d_cq;
  logic [4:0]  d_hq;
  logic [13:0] d_wq;

  assign d_d3_n  = {1'b0, c_days} + ntpcal_pkg::SHIFT_1996;
  assign d_w_n   = {1'b0, c_days} + ntpcal_pkg::WEEK_SHIFT;
  assign d_cprod = 22'(d_d3_n) * 22'(ntpcal_pkg::RECIP_1461);
  assign d_hprod = 19'(c_secs[16:4]) * 19'(ntpcal_pkg::RECIP_225);
  assign d_wprod = 30'(d_w_n) * 30'(ntpcal_pkg::RECIP_7);

  // stage e: corrections
  logic [16:0] e_cp;
  logic [16:0] e_cd;
  logic [11:0] e_cr;
  logic        e_cover;
  logic [12:0] e_hp;
  logic [12:0] e_hd;
  logic [8:0]  e_hr;
  logic        e_hover;
  logic [8:0]  e_hrr;
  logic [15:0] e_wp;
  logic [15:0] e_wd;
  logic [3:0]  e_wr;
  logic [3:0]  e_wrr;
  logic        e_inv;
  logic [5:0]  e_cyc;
  logic [10:0] e_doc;
  logic [4:0]  e_hour;
  logic [11:0] e_rem;
  logic [2:0]  e_wday;

  assign e_cp    = 17'(d_cq) * 17'(ntpcal_pkg::CYCLE_DAYS);
  assign e_cd    = {1'b0, d_d3} - e_cp;
  assign e_cr    = e_cd[11:0];
  assign e_cover = e_cr >= 12'(ntpcal_pkg::CYCLE_DAYS);
  assign e_hp    = 13'(d_hq) * 13'(ntpcal_pkg::HOUR_UNIT);
  assign e_hd    = d_h - e_hp;
  assign e_hr    = e_hd[8:0];
  assign e_hover = e_hr >= 9'(ntpcal_pkg::HOUR_UNIT);
  assign e_hrr   = e_hover ? e_hr - 9'(ntpcal_pkg::HOUR_UNIT) : e_hr;
  assign e_wp    = 16'(d_wq) * 16'd7;
  assign e_wd    = d_w - e_wp;
  assign e_wr    = e_wd[3:0];
  assign e_wrr   = (e_wr >= 4'd7) ? e_wr - 4'd7 : e_wr;

  // stage f: year of cycle, minute estimate
  logic [1:0]  f_yoc;
  logic [10:0] f_doy_n;
  logic [16:0] f_mprod;
  logic        f_inv;
  logic [8:0]  f_doy;
  logic [6:0]  f_year;
  logic [5:0]  f_mq;
  logic [11:0] f_rem;
  logic [4:0]  f_hour;
  logic [2:0]  f_wday;

  always_comb begin
    if (e_doc >= 11'd1095) begin
      f_yoc   = 2'd3;
      f_doy_n = e_doc - 11'd1095;
    end else if (e_doc >= 11'd730) begin
      f_yoc   = 2'd2;
      f_doy_n = e_doc - 11'd730;
    end else if (e_doc >= 11'd365) begin
      f_yoc   = 2'd1;
      f_doy_n = e_doc - 11'd365;
    end else begin
      f_yoc   = 2'd0;
      f_doy_n = e_doc;
    end
  end

  assign f_mprod = 17'(e_rem[11:2]) * 17'(ntpcal_pkg::RECIP_15);

  // stage g: month, day, minute, second
  logic [3:0]  g_mp;
  logic [8:0]  g_day;
  logic [3:0]  g_month;
  logic [6:0]  g_year;
  logic [9:0]  g_mp10;
  logic [9:0]  g_md;
  logic [4:0]  g_mr;
  logic        g_mover;
  logic [4:0]  g_mrr;
  logic [5:0]  g_min;

  always_comb begin
    g_mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (f_doy >= ntpcal_pkg::month_start(4'(k))) begin
        g_mp = 4'(k);
      end
    end
  end

  assign g_day   = f_doy - ntpcal_pkg::month_start(g_mp) + 9'd1;
  assign g_month = (g_mp < 4'd10) ? g_mp + 4'd3 : g_mp - 4'd9;
  assign g_year  = f_year + 7'((g_month <= 4'd2) ? 1 : 0);
  assign g_mp10  = 10'(f_mq) * 10'(ntpcal_pkg::MIN_UNIT);
  assign g_md    = f_rem[11:2] - g_mp10;
  assign g_mr    = g_md[4:0];
  assign g_mover = g_mr >= 5'(ntpcal_pkg::MIN_UNIT);
  assign g_mrr   = g_mover ? g_mr - 5'(ntpcal_pkg::MIN_UNIT) : g_mr;
  assign g_min   = f_mq + 6'(g_mover);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_inv  <= (ntp_seconds < cfg.min_valid) || a_sum[33];
      a_secs <= a_sum[30:0];

      b_inv <= a_inv;
      b_q   <= b_prod[38:24];
      b_x   <= a_secs[30:7];
      b_lo  <= a_secs[6:0];

      c_inv  <= b_inv;
      c_days <= b_q + 15'(c_over);
      c_secs <= {c_rr[9:0], b_lo};

      d_inv <= c_inv;
      d_d3  <= d_d3_n;
      d_w   <= d_w_n;
      d_h   <= c_secs[16:4];
      d_lo  <= c_secs[3:0];
      d_cq  <= d_cprod[21:16];
      d_hq  <= d_hprod[17:13];
      d_wq  <= d_wprod[29:16];

      e_inv  <= d_inv;
      e_cyc  <= d_cq + 6'(e_cover);
      e_doc  <= e_cover ? 11'(e_cr - 12'(ntpcal_pkg::CYCLE_DAYS)) : e_cr[10:0];
      e_hour <= d_hq + 5'(e_hover);
      e_rem  <= {e_hrr[7:0], d_lo};
      e_wday <= e_wrr[2:0] + 3'd1;

      f_inv  <= e_inv;
      f_doy  <= f_doy_n[8:0];
      f_year <= 7'({e_cyc, 2'b00}) + 7'(f_yoc) - 7'd4;
      f_mq   <= f_mprod[15:10];
      f_rem  <= e_rem;
      f_hour <= e_hour;
      f_wday <= e_wday;

      status          <= f_inv;
      year_in_century <= f_inv ? '0 : g_year;
      month           <= f_inv ? '0 : g_month;
      day_of_month    <= f_inv ? '0 : g_day[4:0];
      weekday         <= f_inv ? '0 : f_wday;
      hour            <= f_inv ? '0 : f_hour;
      minute          <= f_inv ? '0 : g_min;
      second          <= f_inv ? '0 : {g_mrr[3:0], f_rem[1:0]};
    end
  end

endmodule

// ===== rtl/core/ntp_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar
// Converts NTP seconds to local calendar date and time of day.
// ----------------------------------------------------------------------------
// Input channel: ntp_valid / ntp_stall with ntp_seconds. A transaction is
// taken at an edge with ntp_valid high and ntp_stall low.
// Output channel: cal_valid / cal_stall with status and the calendar fields,
// one result per input transaction, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high. Index 0 sets the minimum valid NTP seconds, index 1 the
// 17-bit signed zone offset (cfg_data[16:0]); other indexes are ignored.
// One transaction per cycle is sustained while no result is stalled, set by
// the seven-stage divide-by-constant pipeline.
// A stalled result freezes the whole pipeline and raises ntp_stall in the
// same cycle; nothing is dropped or repeated.
// Reset clears the pipeline and loads the register defaults (minimum
// 3913056000, offset +25200 s).
// Rejected timestamps give status 1 with every other field zero.
// ----------------------------------------------------------------------------
module ntp_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        ntp_valid,
  output logic        ntp_stall,
  input  logic [31:0] ntp_seconds,
  output logic        cal_valid,
  input  logic        cal_stall,
  output logic        status,
  output logic [6:0]  year_in_century,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ntpcal_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_valid   <= ntpcal_pkg::MIN_VALID_RESET;
      cfg.zone_offset <= ntpcal_pkg::ZONE_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ntpcal_pkg::REG_MIN_VALID:   cfg.min_valid   <= cfg_data;
        ntpcal_pkg::REG_ZONE_OFFSET: cfg.zone_offset <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  ntpcal_conv u_conv (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ntp_valid       (ntp_valid),
    .ntp_stall       (ntp_stall),
    .ntp_seconds     (ntp_seconds),
    .cal_valid       (cal_valid),
    .cal_stall       (cal_stall),
    .status          (status),
    .year_in_century (year_in_century),
    .month           (month),
    .day_of_month    (day_of_month),
    .weekday         (weekday),
    .hour            (hour),
    .minute          (minute),
    .second          (second)
  );

endmodule

// ===== rtl/core/ntpcal_checker.sv =====
// ----------------------------------------------------------------------------
// ntpcal_checker
// Port-level assertions for the NTP seconds to calendar converter.
// ----------------------------------------------------------------------------
module ntpcal_checker (
  input logic        clk,
  input logic        rst,
  input logic        ntp_valid,
  input logic        ntp_stall,
  input logic [31:0] ntp_seconds,
  input logic        cal_valid,
  input logic        cal_stall,
  input logic        status,
  input logic [6:0]  year_in_century,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [2:0]  weekday,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // rejected transaction carries no date or time
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    cal_valid && status |-> year_in_century == 7'd0 && month == 4'd0 &&
      day_of_month == 5'd0 && weekday == 3'd0 && hour == 5'd0 &&
      minute == 6'd0 && second == 6'd0)
    else $error("rejected result has non-zero fields");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    cal_valid && !status |-> month >= 4'd1 && month <= 4'd12 &&
      day_of_month >= 5'd1 && weekday >= 3'd1 && hour <= 5'd23 &&
      minute <= 6'd59 && second <= 6'd59 && year_in_century <= 7'd99)
    else $error("calendar field out of range");

  // input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    ntp_stall |-> cal_valid && cal_stall)
    else $error("input stalled without output stall");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    cal_valid && cal_stall |=> cal_valid && $stable(status) &&
      $stable(year_in_century) && $stable(month) && $stable(day_of_month) &&
      $stable(weekday) && $stable(hour) && $stable(minute) && $stable(second))
    else $error("stalled result changed");

endmodule

bind ntp_seconds_to_calendar ntpcal_checker u_ntpcal_checker (.*);
